// File: rtl/igpr_pkg.sv
`default_nettype none
package igpr_pkg;

   // fraction bits of the matrix coefficients
   localparam int unsigned FRAC_A = 28;
   // quotient magnitude width: 33-bit numerator shifted up by FRAC_A
   localparam int unsigned QUO_W = 33 + FRAC_A;
   // number of configuration registers
   localparam int unsigned NUM_REGS = 6;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DIV0 = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_ROW0_LO = 3'd0,
      REG_ROW0_HI = 3'd1,
      REG_ROW1_LO = 3'd2,
      REG_ROW1_HI = 3'd3,
      REG_ROW2_LO = 3'd4,
      REG_ROW2_HI = 3'd5
   } reg_index_type;

endpackage
`default_nettype wire

// File: rtl/image_to_ground_plane_reprojection.sv
`default_nettype none
// Channel   Dir  Ports                               Word
// req       in   req_tvalid/tready/tdata             pixel_x, pixel_y, plane_z
// rsp       out  rsp_tvalid/tready/tdata/tuser       world_x, world_y, world_z; status
// csr       in   csr_valid/ready/index/data          one 64-bit register write
//
// One word accepted per cycle while rsp is not stalled; the restoring
// divider resolves one quotient bit per stage over 61 stages.
// Reset is synchronous and clears the valid bits and the registers.
// A stall at rsp freezes the whole pipeline; req_tready follows it, so
// nothing is lost or repeated. csr_ready is always high.
module image_to_ground_plane_reprojection #(
   parameter int PIXEL_BITS = 12
) (
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   input  wire  logic                 req_tvalid,
   output logic                       req_tready,
   // pixel_x, pixel_y, plane_z, zero pad
   input  wire  logic [((2*PIXEL_BITS+32+7)/8)*8-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire  logic                 rsp_tready,
   // world_x, world_y, world_z
   output logic [95:0]                rsp_tdata,
   // status
   output logic [1:0]                 rsp_tuser,
   input  wire  logic                 csr_valid,
   output logic                       csr_ready,
   input  wire  logic [2:0]           csr_index,
   input  wire  logic [63:0]          csr_data
);

   localparam int PW = PIXEL_BITS;
   localparam int MW = PIXEL_BITS + 34;      // signed ray component width
   localparam int PRW = PIXEL_BITS + 33;     // coefficient times pixel
   localparam int QW = igpr_pkg::QUO_W;
   localparam int FA = igpr_pkg::FRAC_A;

   // configuration registers
   logic [63:0] cfg_ff [igpr_pkg::NUM_REGS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < igpr_pkg::NUM_REGS; i++) cfg_ff[i] <= '0;
      end else if (csr_valid) begin
         case (igpr_pkg::reg_index_type'(csr_index))
            igpr_pkg::REG_ROW0_LO: cfg_ff[0] <= csr_data;
            igpr_pkg::REG_ROW0_HI: cfg_ff[1] <= csr_data;
            igpr_pkg::REG_ROW1_LO: cfg_ff[2] <= csr_data;
            igpr_pkg::REG_ROW1_HI: cfg_ff[3] <= csr_data;
            igpr_pkg::REG_ROW2_LO: cfg_ff[4] <= csr_data;
            igpr_pkg::REG_ROW2_HI: cfg_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline advances when the output register is free or taken
   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage 0: input capture
   logic                s0_vld_ff;
   logic [PW-1:0]       s0_x_ff, s0_y_ff;
   logic signed [31:0]  s0_z_ff;

   always_ff @(posedge clock) begin
      if (reset) s0_vld_ff <= 1'b0;
      else if (en) s0_vld_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s0_x_ff <= req_tdata[PW-1:0];
         s0_y_ff <= req_tdata[2*PW-1:PW];
         s0_z_ff <= req_tdata[2*PW+31:2*PW];
      end
   end

   // stage 1: coefficient times pixel products
   logic                   m1_vld_ff;
   logic signed [PRW-1:0]  m1_px_ff [3];
   logic signed [PRW-1:0]  m1_py_ff [3];
   logic signed [31:0]     m1_z_ff;

   always_ff @(posedge clock) begin
      if (reset) m1_vld_ff <= 1'b0;
      else if (en) m1_vld_ff <= s0_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            m1_px_ff[r] <= $signed(cfg_ff[2*r][31:0]) * $signed({1'b0, s0_x_ff});
            m1_py_ff[r] <= $signed(cfg_ff[2*r][63:32]) * $signed({1'b0, s0_y_ff});
         end
         m1_z_ff <= s0_z_ff;
      end
   end

   // stage 2: ray components and numerator
   logic                  m2_vld_ff;
   logic signed [MW-1:0]  m2_m_ff [3];
   logic signed [32:0]    m2_s_ff;
   logic signed [31:0]    m2_z_ff;

   always_ff @(posedge clock) begin
      if (reset) m2_vld_ff <= 1'b0;
      else if (en) m2_vld_ff <= m1_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            m2_m_ff[r] <= MW'(m1_px_ff[r]) + MW'(m1_py_ff[r])
                          + MW'($signed(cfg_ff[2*r+1][31:0]));
         end
         m2_s_ff <= 33'(m1_z_ff) + 33'($signed(cfg_ff[5][63:32]));
         m2_z_ff <= m1_z_ff;
      end
   end

   // stage 3 and divider: index 0 holds magnitudes, each later index one bit
   logic               dv_vld_ff  [QW+1];
   logic [MW-1:0]      dv_rem_ff  [QW+1];
   logic [QW-1:0]      dv_nq_ff   [QW+1];
   logic [MW-1:0]      dv_den_ff  [QW+1];
   logic [MW-1:0]      dv_mag0_ff [QW+1];
   logic [MW-1:0]      dv_mag1_ff [QW+1];
   logic               dv_neg0_ff [QW+1];
   logic               dv_neg1_ff [QW+1];
   logic               dv_zero_ff [QW+1];
   logic signed [31:0] dv_z_ff    [QW+1];

   logic [32:0]        s_mag;
   logic               sk;
   assign s_mag = m2_s_ff[32] ? 33'(-m2_s_ff) : 33'(m2_s_ff);
   assign sk = m2_s_ff[32] ^ m2_m_ff[2][MW-1];

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff[0] <= 1'b0;
      else if (en) dv_vld_ff[0] <= m2_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_ff[0]  <= '0;
         dv_nq_ff[0]   <= {s_mag, {FA{1'b0}}};
         dv_den_ff[0]  <= m2_m_ff[2][MW-1] ? MW'(-m2_m_ff[2]) : MW'(m2_m_ff[2]);
         dv_mag0_ff[0] <= m2_m_ff[0][MW-1] ? MW'(-m2_m_ff[0]) : MW'(m2_m_ff[0]);
         dv_mag1_ff[0] <= m2_m_ff[1][MW-1] ? MW'(-m2_m_ff[1]) : MW'(m2_m_ff[1]);
         dv_neg0_ff[0] <= sk ^ m2_m_ff[0][MW-1];
         dv_neg1_ff[0] <= sk ^ m2_m_ff[1][MW-1];
         dv_zero_ff[0] <= (m2_m_ff[2] == '0);
         dv_z_ff[0]    <= m2_z_ff;
      end
   end

   for (genvar g = 0; g < QW; g++) begin : g_div
      logic [MW:0]   trial_in;
      logic          take_in;
      logic [MW-1:0] rem_in;
      assign trial_in = {dv_rem_ff[g], dv_nq_ff[g][QW-1]};
      assign take_in = trial_in >= {1'b0, dv_den_ff[g]};
      assign rem_in = take_in ? MW'(trial_in - {1'b0, dv_den_ff[g]})
                              : trial_in[MW-1:0];

      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[g+1] <= 1'b0;
         else if (en) dv_vld_ff[g+1] <= dv_vld_ff[g];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[g+1]  <= rem_in;
            dv_nq_ff[g+1]   <= {dv_nq_ff[g][QW-2:0], take_in};
            dv_den_ff[g+1]  <= dv_den_ff[g];
            dv_mag0_ff[g+1] <= dv_mag0_ff[g];
            dv_mag1_ff[g+1] <= dv_mag1_ff[g];
            dv_neg0_ff[g+1] <= dv_neg0_ff[g];
            dv_neg1_ff[g+1] <= dv_neg1_ff[g];
            dv_zero_ff[g+1] <= dv_zero_ff[g];
            dv_z_ff[g+1]    <= dv_z_ff[g];
         end
      end
   end

   // scale stages: valid, zero flag and z travel alongside the lanes
   logic               p_vld_ff  [5];
   logic               p_zero_ff [5];
   logic signed [31:0] p_z_ff    [5];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) p_vld_ff[i] <= 1'b0;
      end else if (en) begin
         p_vld_ff[0] <= dv_vld_ff[QW];
         for (int i = 1; i < 5; i++) p_vld_ff[i] <= p_vld_ff[i-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         p_zero_ff[0] <= dv_zero_ff[QW];
         p_z_ff[0]    <= dv_z_ff[QW];
         for (int i = 1; i < 5; i++) begin
            p_zero_ff[i] <= p_zero_ff[i-1];
            p_z_ff[i]    <= p_z_ff[i-1];
         end
      end
   end

   logic [63:0]        k_pad;
   assign k_pad = 64'(dv_nq_ff[QW]);

   logic signed [31:0] lane_w [2];
   logic               lane_sat [2];

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [63:0]        m_pad;
      logic               neg_in;
      logic signed [31:0] b_in;
      assign m_pad  = (l == 0) ? 64'(dv_mag0_ff[QW]) : 64'(dv_mag1_ff[QW]);
      assign neg_in = (l == 0) ? dv_neg0_ff[QW] : dv_neg1_ff[QW];
      assign b_in   = $signed(cfg_ff[2*l+1][63:32]);

      // partial products
      logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
      logic        n1_ff, n2_ff, n3_ff, n4_ff;
      always_ff @(posedge clock) begin
         if (en) begin
            p00_ff <= k_pad[31:0]  * m_pad[31:0];
            p01_ff <= k_pad[31:0]  * m_pad[63:32];
            p10_ff <= k_pad[63:32] * m_pad[31:0];
            p11_ff <= k_pad[63:32] * m_pad[63:32];
            n1_ff  <= neg_in;
         end
      end

      // middle column sum
      logic [65:0] mid_ff;
      logic [31:0] lo_ff;
      logic [63:0] hi_ff;
      always_ff @(posedge clock) begin
         if (en) begin
            mid_ff <= 66'(p00_ff[63:32]) + 66'(p01_ff) + 66'(p10_ff);
            lo_ff  <= p00_ff[31:0];
            hi_ff  <= p11_ff;
            n2_ff  <= n1_ff;
         end
      end

      // full 128-bit product
      logic [127:0] prod_ff;
      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff <= {hi_ff + 64'(mid_ff[65:32]), mid_ff[31:0], lo_ff};
            n3_ff   <= n2_ff;
         end
      end

      // shift down, range check, floor rounding, sign
      logic [99:0]        q_in;
      logic               ovf_in;
      logic               frac_in;
      logic [41:0]        qmag_in;
      logic signed [43:0] v_ff;
      logic               ovf_ff;
      assign q_in    = prod_ff[127:FA];
      assign frac_in = |prod_ff[FA-1:0];
      assign ovf_in  = (|q_in[99:41]) || (q_in[40] && (|q_in[39:0]));
      assign qmag_in = 42'(q_in[40:0]) + 42'(n3_ff && frac_in);
      always_ff @(posedge clock) begin
         if (en) begin
            v_ff   <= n3_ff ? -44'(qmag_in) : 44'(qmag_in);
            ovf_ff <= ovf_in;
            n4_ff  <= n3_ff;
         end
      end

      // subtract offset and clamp
      logic signed [44:0] r_in;
      logic signed [31:0] w_ff;
      logic               sat_ff;
      assign r_in = 45'(v_ff) - 45'(b_in);
      always_ff @(posedge clock) begin
         if (en) begin
            if (ovf_ff) begin
               w_ff   <= n4_ff ? 32'sh8000_0000 : 32'sh7fff_ffff;
               sat_ff <= 1'b1;
            end else if (r_in > 45'sd2147483647) begin
               w_ff   <= 32'sh7fff_ffff;
               sat_ff <= 1'b1;
            end else if (r_in < -45'sd2147483648) begin
               w_ff   <= 32'sh8000_0000;
               sat_ff <= 1'b1;
            end else begin
               w_ff   <= r_in[31:0];
               sat_ff <= 1'b0;
            end
         end
      end
      assign lane_w[l]   = w_ff;
      assign lane_sat[l] = sat_ff;
   end

   // output word; divide by zero overrides the lanes
   assign rsp_tvalid = p_vld_ff[4];
   always_comb begin
      if (p_zero_ff[4]) begin
         rsp_tdata = {p_z_ff[4], 32'd0, 32'd0};
         rsp_tuser = igpr_pkg::STATUS_DIV0;
      end else begin
         rsp_tdata = {p_z_ff[4], lane_w[1], lane_w[0]};
         rsp_tuser = (lane_sat[0] || lane_sat[1]) ? igpr_pkg::STATUS_SAT
                                                  : igpr_pkg::STATUS_OK;
      end
   end

endmodule
`default_nettype wire
